>>> sv/tbi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tbi_pkg;

	localparam int COORD_W      = 16;
	localparam int VALUE_W      = 16;
	localparam int CFG_W        = 2 * COORD_W;
	localparam int CFG_IDX_W    = 3;

	localparam int DIFF_W       = COORD_W + 1;
	localparam int PROD_W       = 2 * DIFF_W;
	localparam int CROSS_W      = PROD_W + 1;
	localparam int WEIGHT_W     = CROSS_W - 1;
	localparam int TOTAL_W      = WEIGHT_W + 2;
	localparam int TERM_W       = VALUE_W + WEIGHT_W + 1;
	localparam int NUM_W        = TERM_W + 2;
	localparam int QUO_W        = VALUE_W;
	localparam int REM_W        = TOTAL_W + QUO_W;

	localparam int FRONT_STAGES = 6;
	localparam int RESULT_LAT   = FRONT_STAGES + QUO_W + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_A_POS = 3'd0,
		REG_B_POS = 3'd1,
		REG_C_POS = 3'd2,
		REG_A_VAL = 3'd3,
		REG_B_VAL = 3'd4,
		REG_C_VAL = 3'd5
	} cfg_reg_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [WEIGHT_W-1:0] weight_t;

	typedef struct packed {
		logic neg;
		logic deg;
		logic [REM_W-1:0] rem;
		logic [REM_W-1:0] dvsr;
		logic [QUO_W-1:0] quo;
	} div_word_t;

endpackage

`default_nettype wire

>>> sv/tbi_weights.sv
`timescale 1ns / 1ps
`default_nettype none

module tbi_weights (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire tbi_pkg::coord_t px,
	input  wire tbi_pkg::coord_t py,
	input  wire logic [tbi_pkg::CFG_W-1:0] pos [3],
	output logic out_valid,
	output tbi_pkg::weight_t weight [3]
);
	import tbi_pkg::*;

	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [CROSS_W-1:0] cross_t;

	// edge i runs from vertex i to vertex NXT[i]: AB, BC, CA
	localparam int NXT [3] = '{1, 2, 0};

	coord_t  vx [3];
	coord_t  vy [3];
	diff_t   ex_s1 [3];
	diff_t   ey_s1 [3];
	diff_t   qx_s1 [3];
	diff_t   qy_s1 [3];
	prod_t   pa_s2 [3];
	prod_t   pb_s2 [3];
	cross_t  cross_c [3];
	cross_t  abs_c [3];
	weight_t weight_s3 [3];
	logic    valid_s1, valid_s2, valid_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vx[i] = pos[i][CFG_W-1:COORD_W];
			vy[i] = pos[i][COORD_W-1:0];
			cross_c[i] = cross_t'(pa_s2[i]) - cross_t'(pb_s2[i]);
			abs_c[i] = cross_c[i][CROSS_W-1] ? -cross_c[i] : cross_c[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			ex_s1[i] <= diff_t'(vx[NXT[i]]) - diff_t'(vx[i]);
			ey_s1[i] <= diff_t'(vy[NXT[i]]) - diff_t'(vy[i]);
			qx_s1[i] <= diff_t'(px) - diff_t'(vx[i]);
			qy_s1[i] <= diff_t'(py) - diff_t'(vy[i]);
			pa_s2[i] <= ex_s1[i] * qy_s1[i];
			pb_s2[i] <= ey_s1[i] * qx_s1[i];
			weight_s3[i] <= abs_c[i][WEIGHT_W-1:0];
		end
	end

	assign out_valid = valid_s3;
	assign weight = weight_s3;

endmodule

`default_nettype wire

>>> sv/tbi_numer.sv
`timescale 1ns / 1ps
`default_nettype none

module tbi_numer (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire tbi_pkg::weight_t weight [3],
	input  wire tbi_pkg::value_t vals [3],
	output logic out_valid,
	output tbi_pkg::div_word_t word
);
	import tbi_pkg::*;

	typedef logic signed [TERM_W-1:0] term_t;
	typedef logic signed [NUM_W-1:0] num_t;

	// vertex i pairs with the weight of the opposite edge
	localparam int OPP [3] = '{1, 2, 0};

	logic [TOTAL_W-1:0] total_s4, total_s5;
	term_t      term_s4 [3];
	num_t       num_s5;
	logic [NUM_W-1:0] mag_c;
	div_word_t  word_s6;
	logic       valid_s4, valid_s5, valid_s6;

	assign mag_c = num_s5[NUM_W-1] ? -num_s5 : num_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s4 <= in_valid;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		total_s4 <= TOTAL_W'(weight[0]) + TOTAL_W'(weight[1]) + TOTAL_W'(weight[2]);
		for (int i = 0; i < 3; i++) begin
			term_s4[i] <= vals[i] * $signed({1'b0, weight[OPP[i]]});
		end
		num_s5 <= num_t'(term_s4[0]) + num_t'(term_s4[1]) + num_t'(term_s4[2]);
		total_s5 <= total_s4;
		word_s6.neg <= num_s5[NUM_W-1];
		word_s6.deg <= (total_s5 == '0);
		word_s6.rem <= mag_c[REM_W-1:0];
		word_s6.dvsr <= REM_W'(total_s5) << (QUO_W - 1);
		word_s6.quo <= '0;
	end

	assign out_valid = valid_s6;
	assign word = word_s6;

endmodule

`default_nettype wire

>>> sv/tbi_div_step.sv
`timescale 1ns / 1ps
`default_nettype none

module tbi_div_step (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire tbi_pkg::div_word_t in_word,
	output logic out_valid,
	output tbi_pkg::div_word_t out_word
);
	import tbi_pkg::*;

	div_word_t next_c;
	div_word_t word_s1;
	logic      ge_c;
	logic      valid_s1;

	// one restoring step: divisor walks right one bit per stage
	always_comb begin
		ge_c = (in_word.rem >= in_word.dvsr);
		next_c = in_word;
		next_c.rem = ge_c ? (in_word.rem - in_word.dvsr) : in_word.rem;
		next_c.dvsr = in_word.dvsr >> 1;
		next_c.quo = {in_word.quo[QUO_W-2:0], ge_c};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		word_s1 <= next_c;
	end

	assign out_valid = valid_s1;
	assign out_word = word_s1;

endmodule

`default_nettype wire

>>> sv/triangle_barycentric_interpolator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Barycentric interpolation over one configured triangle.
// Config: write cfg_data to register cfg_index while cfg_we is high; 0..2 are the
// vertex positions (x in the upper half, y in the lower half), 3..5 the signed
// vertex values. Write only while no point is in flight.
// Input: a point word (point_x, point_y) is taken on a clock edge where start is
// high and busy is low. busy is high only in the first cycle after reset.
// Output: done is high for exactly one cycle with interpolated_value and
// degenerate; the receiver cannot hold it off. degenerate is 1 and the value 0
// when the three sub-triangle weights sum to zero.
// Path: an accepted point passes the weight registers (s1..s3), the numerator
// registers (s4..s6), the 16-stage restoring divider with one quotient bit per
// stage, and the output register.
// Throughput: one point per clock while busy is low, fully pipelined.
// Reset clears the configuration registers and all stage valid bits; points in
// flight are dropped.
module triangle_barycentric_interpolator_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire tbi_pkg::coord_t point_x,
	input  wire tbi_pkg::coord_t point_y,
	input  wire logic cfg_we,
	input  wire logic [tbi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tbi_pkg::CFG_W-1:0] cfg_data,
	output logic done,
	output tbi_pkg::value_t interpolated_value,
	output logic degenerate
);
	import tbi_pkg::*;

	logic [CFG_W-1:0] pos_q [3];
	value_t    val_q [3];
	logic      busy_q;
	logic      accept;
	logic      wt_valid;
	weight_t   wt [3];
	logic      div_valid [QUO_W+1];
	div_word_t div_word [QUO_W+1];
	div_word_t last_word;
	logic [QUO_W-1:0] quo_neg;
	logic      done_q;
	value_t    value_q;
	logic      deg_q;

	assign accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				pos_q[i] <= '0;
				val_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_A_POS: pos_q[0] <= cfg_data;
				REG_B_POS: pos_q[1] <= cfg_data;
				REG_C_POS: pos_q[2] <= cfg_data;
				REG_A_VAL: val_q[0] <= cfg_data[VALUE_W-1:0];
				REG_B_VAL: val_q[1] <= cfg_data[VALUE_W-1:0];
				REG_C_VAL: val_q[2] <= cfg_data[VALUE_W-1:0];
				default: ;
			endcase
		end
	end

	tbi_weights u_weights (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.px       (point_x),
		.py       (point_y),
		.pos      (pos_q),
		.out_valid(wt_valid),
		.weight   (wt)
	);

	tbi_numer u_numer (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (wt_valid),
		.weight   (wt),
		.vals     (val_q),
		.out_valid(div_valid[0]),
		.word     (div_word[0])
	);

	for (genvar g = 0; g < QUO_W; g++) begin : g_div
		tbi_div_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (div_valid[g]),
			.in_word  (div_word[g]),
			.out_valid(div_valid[g+1]),
			.out_word (div_word[g+1])
		);
	end

	assign last_word = div_word[QUO_W];
	assign quo_neg = '0 - last_word.quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else begin
			busy_q <= 1'b0;
			done_q <= div_valid[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		deg_q <= last_word.deg;
		if (last_word.deg) begin
			value_q <= '0;
		end else if (last_word.neg) begin
			value_q <= quo_neg;
		end else begin
			value_q <= last_word.quo;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign interpolated_value = value_q;
	assign degenerate = deg_q;

`ifndef SYNTHESIS
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##RESULT_LAT done)
		else $error("result word missing after accepted point");

	a_result_caused: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, RESULT_LAT))
		else $error("result word without accepted point");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |-> (interpolated_value == '0))
		else $error("degenerate result with nonzero value");

	a_busy_stays_low: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !busy)
		else $error("busy rose after reset");
`endif

endmodule

`default_nettype wire
